@@ rtl/core/ids_pkg.sv @@
// Shared types, character codes and default sizes for the indent/dedent scanner.
`timescale 1ns / 1ps

package ids_pkg;

	// Default sizes for the top-level parameters
	localparam int STACK_DEPTH_DEF = 32;
	localparam int LEVEL_WIDTH_DEF = 16;

	// Character codes the front end looks for
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// Token kinds as seen on the result port
	typedef enum logic [1:0] {
		KIND_NEWLINE = 2'd0,
		KIND_INDENT  = 2'd1,
		KIND_DEDENT  = 2'd2
	} ids_kind_t;

	// Classified character handed from the front end to the back end
	typedef struct packed {
		logic consumed;
		logic scan_done;
		logic line_end;
		logic allow_indent;
		logic allow_dedent;
		logic allow_newline;
	} ids_ctl_t;

	// One result beat
	typedef struct packed {
		logic      consumed;
		logic      scan_done;
		logic      token_valid;
		ids_kind_t token_kind;
		logic      stack_full;
	} ids_res_t;

endpackage

@@ rtl/core/indent_dedent_scanner.sv @@
// Top level of the indent/dedent scanner: front end, middle queue, back end, result queue.
//
//   channel  ports                                              handshake
//   input    ch, scan_start, allow_indent/dedent/newline         push / full
//   result   consumed, scan_done, token_valid, token_kind,       empty / pop
//            stack_full
//
// One character is taken per cycle while full is low, one result beat leaves per cycle
// while empty is low and pop is high; the front end classifies a beat in the cycle it is
// accepted, the back end compares it with the top register and the prefetched entry below
// it once it heads the middle queue and the result queue has room, and pushes the result.
// Reset leaves the stack holding only the zero bottom level; the stack RAM is not
// cleared, since the bottom entry reads as zero through a flag and every other entry is
// written before it is read.
// full rises only after the result queue has filled, once two more beats wait in the
// middle queue; with pop held high it never rises.
`timescale 1ns / 1ps

module indent_dedent_scanner #(
	parameter int STACK_DEPTH = ids_pkg::STACK_DEPTH_DEF,
	parameter int LEVEL_WIDTH = ids_pkg::LEVEL_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	input  logic       scan_start,
	input  logic       allow_indent,
	input  logic       allow_dedent,
	input  logic       allow_newline,
	output logic       empty,
	input  logic       pop,
	output logic       consumed,
	output logic       scan_done,
	output logic       token_valid,
	output logic [1:0] token_kind,
	output logic       stack_full
);

	localparam int MW = $bits(ids_pkg::ids_ctl_t) + LEVEL_WIDTH;
	localparam int RW = $bits(ids_pkg::ids_res_t);

	ids_pkg::ids_ctl_t      f_ctl;
	logic [LEVEL_WIDTH-1:0] f_tab;
	ids_pkg::ids_ctl_t      b_ctl;
	logic [LEVEL_WIDTH-1:0] b_tab;
	logic [MW-1:0]          mid_rdata;
	logic                   mid_empty;
	logic                   accept;
	logic                   fire;
	logic                   out_full;
	ids_pkg::ids_res_t      b_res;
	ids_pkg::ids_res_t      o_res;
	logic [RW-1:0]          out_rdata;

	assign accept = push && !full;

	ids_front #(
		.LEVEL_WIDTH(LEVEL_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ch           (ch),
		.scan_start   (scan_start),
		.allow_indent (allow_indent),
		.allow_dedent (allow_dedent),
		.allow_newline(allow_newline),
		.ctl          (f_ctl),
		.tab          (f_tab)
	);

	ids_fifo #(
		.WIDTH(MW)
	) u_mid (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({f_ctl, f_tab}),
		.full  (full),
		.pop   (fire),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	// Split the queued beat back into control and count
	assign b_ctl = ids_pkg::ids_ctl_t'(mid_rdata[MW-1:LEVEL_WIDTH]);
	assign b_tab = mid_rdata[LEVEL_WIDTH-1:0];

	ids_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.LEVEL_WIDTH(LEVEL_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.ctl      (b_ctl),
		.tab      (b_tab),
		.out_ready(!out_full),
		.fire     (fire),
		.res      (b_res)
	);

	ids_fifo #(
		.WIDTH(RW)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.wdata (b_res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	// Drive the result ports from the oldest beat
	assign o_res       = ids_pkg::ids_res_t'(out_rdata);
	assign consumed    = o_res.consumed;
	assign scan_done   = o_res.scan_done;
	assign token_valid = o_res.token_valid;
	assign token_kind  = o_res.token_kind;
	assign stack_full  = o_res.stack_full;

endmodule

@@ rtl/core/ids_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ids_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/ids_fifo.sv @@
// Two-entry register queue used between the front end, the back end and the output.
`timescale 1ns / 1ps

module ids_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ rtl/core/ids_front.sv @@
// Front end: classify each character and track the tab count and line-end flag.
`timescale 1ns / 1ps

module ids_front #(
	parameter int LEVEL_WIDTH = ids_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             ch,
	input  logic                   scan_start,
	input  logic                   allow_indent,
	input  logic                   allow_dedent,
	input  logic                   allow_newline,
	output ids_pkg::ids_ctl_t      ctl,
	output logic [LEVEL_WIDTH-1:0] tab
);

	logic [LEVEL_WIDTH-1:0] tab_q;
	logic                   line_q;
	logic [LEVEL_WIDTH-1:0] tab_base;
	logic                   line_base;
	logic [LEVEL_WIDTH-1:0] tab_n;
	logic                   line_n;

	// Classify the character and form the next count and flag
	always_comb begin
		tab_base = scan_start ? '0 : tab_q;
		line_base = scan_start ? 1'b0 : line_q;
		tab_n = tab_base;
		line_n = line_base;
		ctl.consumed = 1'b0;
		ctl.scan_done = 1'b0;
		case (ch)
			ids_pkg::CH_LF: begin
				line_n = 1'b1;
				tab_n = '0;
				ctl.consumed = 1'b1;
			end
			ids_pkg::CH_CR, ids_pkg::CH_FF: begin
				tab_n = '0;
				ctl.consumed = 1'b1;
			end
			ids_pkg::CH_TAB: begin
				if (tab_base != '1) begin
					tab_n = tab_base + LEVEL_WIDTH'(1);
				end
				ctl.consumed = 1'b1;
			end
			ids_pkg::CH_NUL: begin
				line_n = 1'b1;
				tab_n = '0;
				ctl.scan_done = 1'b1;
			end
			default: begin
				ctl.scan_done = 1'b1;
			end
		endcase
		ctl.line_end = line_n;
		ctl.allow_indent = allow_indent;
		ctl.allow_dedent = allow_dedent;
		ctl.allow_newline = allow_newline;
		tab = tab_n;
	end

	// Hold the scan state between characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q  <= '0;
			line_q <= 1'b0;
		end else if (accept) begin
			tab_q  <= tab_n;
			line_q <= line_n;
		end
	end

endmodule

@@ rtl/core/ids_back.sv @@
// Back end: compare with the indent stack, push or pop, and build the result beat.
`timescale 1ns / 1ps

module ids_back #(
	parameter int STACK_DEPTH = ids_pkg::STACK_DEPTH_DEF,
	parameter int LEVEL_WIDTH = ids_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ids_pkg::ids_ctl_t      ctl,
	input  logic [LEVEL_WIDTH-1:0] tab,
	input  logic                   out_ready,
	output logic                   fire,
	output ids_pkg::ids_res_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// Top of stack in a register, entry below it from the RAM
	logic [LEVEL_WIDTH-1:0] top_q;
	logic [LEVEL_WIDTH-1:0] top_n;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_n;
	logic [CW-1:0]          cnt_m2;
	logic                   zero_q;
	logic                   zero_n;
	logic [LEVEL_WIDTH-1:0] below;
	logic [LEVEL_WIDTH-1:0] rdata;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic                   is_ind;
	logic                   is_ded;

	assign fire  = in_valid && out_ready;
	assign below = zero_q ? '0 : rdata;

	// Decide the token and the stack update
	always_comb begin
		top_n = top_q;
		cnt_n = cnt_q;
		we = 1'b0;
		is_ind = ctl.allow_indent && (tab > top_q);
		is_ded = ctl.allow_dedent && (tab < top_q);
		res.consumed = ctl.consumed;
		res.scan_done = ctl.scan_done;
		res.token_valid = 1'b0;
		res.token_kind = ids_pkg::KIND_NEWLINE;
		res.stack_full = 1'b0;
		if (ctl.scan_done && ctl.line_end) begin
			if (is_ind) begin
				res.token_valid = 1'b1;
				res.token_kind = ids_pkg::KIND_INDENT;
				if (cnt_q < CW'(STACK_DEPTH)) begin
					we = fire;
					if (fire) begin
						top_n = tab;
						cnt_n = cnt_q + CW'(1);
					end
				end else begin
					res.stack_full = 1'b1;
				end
			end else if (is_ded) begin
				res.token_valid = 1'b1;
				res.token_kind = ids_pkg::KIND_DEDENT;
				if (fire && (cnt_q > CW'(1))) begin
					top_n = below;
					cnt_n = cnt_q - CW'(1);
				end
			end else if (ctl.allow_newline) begin
				res.token_valid = 1'b1;
			end
		end
	end

	// Prefetch the entry below the next top
	always_comb begin
		cnt_m2 = cnt_n - CW'(2);
		zero_n = (cnt_n <= CW'(2));
		raddr = zero_n ? '0 : cnt_m2[AW-1:0];
	end

	// Advance the stack pointer and top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			cnt_q  <= CW'(1);
			zero_q <= 1'b1;
		end else begin
			top_q  <= top_n;
			cnt_q  <= cnt_n;
			zero_q <= zero_n;
		end
	end

	ids_ram #(
		.WIDTH(LEVEL_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(tab),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule
